### hdl/cls_pkg.sv
// Shared types and constants for the changed label set tracker.
// Holds the transfer structs, request codes, controller states and the
// command and status bundles. Depends on nothing.
`default_nettype none

package cls_pkg;

  // Default label width of the mark map address.
  localparam int LABEL_BITS_DEF = 16;
  // Fixed width of the label fields on the ports.
  localparam int FIELD_BITS = 16;
  // Each memory row holds 2**ROW_LOG marks.
  localparam int ROW_LOG = 3;
  localparam int ROW_WIDTH = 1 << ROW_LOG;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_PAIR  = 2'd0,
    REQ_FETCH = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Input transfer.
  typedef struct packed {
    req_t                  req_type;
    logic [FIELD_BITS-1:0] old_label;
    logic [FIELD_BITS-1:0] new_label;
  } in_item_t;

  // Result transfer.
  typedef struct packed {
    logic [FIELD_BITS-1:0] changed_label;
    logic                  label_found;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_A,
    ST_MARK_B,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture the labels of an accepted transfer
    logic clr_start;  // restart the clearing sweep and the cursor
    logic clr_wr;     // clear one map row and step the sweep counter
    logic mark_a;     // set the mark of the old label
    logic mark_b;     // set the mark of the new label
    logic scan_rd;    // read the map row under the cursor
    logic scan_chk;   // examine the row read and advance the cursor
    logic res_hit;    // record a found label as the pending result
    logic res_none;   // record a not-found pending result
    logic out_load;   // move the pending result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;     // the sweep is on the last row
    logic labels_diff;  // the captured labels differ
    logic cursor_done;  // the cursor has passed the last label
    logic row_hit;      // the row read holds a mark at or above the cursor
    logic out_free;     // the output register can take a result
  } status_t;

endpackage : cls_pkg

`default_nettype wire

### hdl/cls_dp.sv
// Datapath of the changed label set tracker: mark map memory, scan cursor,
// clearing sweep counter and output register.
// Depends on cls_pkg.
`default_nettype none

module cls_dp #(
  parameter int LABEL_BITS = cls_pkg::LABEL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cls_pkg::in_item_t  in_data,
  input  wire logic               out_stall,
  input  wire cls_pkg::cmd_t      cmd,
  output cls_pkg::status_t        status,
  output logic                    out_valid,
  output cls_pkg::out_item_t      out_data
);

  import cls_pkg::*;

  localparam int ADDR_BITS = LABEL_BITS - ROW_LOG;
  localparam int ROW_COUNT = 1 << ADDR_BITS;

  // Mark map, one row of ROW_WIDTH marks per address.
  logic [ROW_WIDTH-1:0] map_mem [ROW_COUNT];

  logic [LABEL_BITS-1:0] old_r, new_r;
  logic [LABEL_BITS:0]   cursor_r, cursor_nxt;
  logic [ADDR_BITS-1:0]  clr_cnt_r;
  logic [ROW_WIDTH-1:0]  rd_data_r;
  logic [FIELD_BITS-1:0] res_label_r;
  logic                  res_found_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [LABEL_BITS+FIELD_BITS-1:0] old_ext, new_ext;
  logic [LABEL_BITS+FIELD_BITS-1:0] lab_ext;
  logic [ADDR_BITS-1:0]  cur_row;
  logic [ROW_LOG-1:0]    cur_off;
  logic [ROW_WIDTH-1:0]  masked;
  logic [ROW_LOG-1:0]    hit_idx;
  logic [LABEL_BITS-1:0] hit_label;
  logic [ADDR_BITS:0]    next_row;

  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [ROW_WIDTH-1:0]  wr_mask;
  logic                  wr_bit;

  // Cut or widen the port labels to the map address width.
  assign old_ext = {{LABEL_BITS{1'b0}}, in_data.old_label};
  assign new_ext = {{LABEL_BITS{1'b0}}, in_data.new_label};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      old_r <= old_ext[LABEL_BITS-1:0];
      new_r <= new_ext[LABEL_BITS-1:0];
    end
  end

  // Write port: the sweep clears whole rows, marking sets a single bit.
  always_comb begin
    wr_en   = cmd.clr_wr | cmd.mark_a | cmd.mark_b;
    wr_bit  = !cmd.clr_wr;
    wr_addr = clr_cnt_r;
    wr_mask = {ROW_WIDTH{1'b1}};
    if (cmd.mark_a) begin
      wr_addr = old_r[LABEL_BITS-1:ROW_LOG];
      wr_mask = ROW_WIDTH'(1) << old_r[ROW_LOG-1:0];
    end else if (cmd.mark_b) begin
      wr_addr = new_r[LABEL_BITS-1:ROW_LOG];
      wr_mask = ROW_WIDTH'(1) << new_r[ROW_LOG-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < ROW_WIDTH; i++) begin
        if (wr_mask[i]) begin
          map_mem[wr_addr][i] <= wr_bit;
        end
      end
    end
  end

  // Registered read of the row under the cursor.
  assign cur_row = cursor_r[LABEL_BITS-1:ROW_LOG];
  assign cur_off = cursor_r[ROW_LOG-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data_r <= map_mem[cur_row];
    end
  end

  // Lowest mark in the row at or above the cursor offset.
  always_comb begin
    masked  = rd_data_r & ({ROW_WIDTH{1'b1}} << cur_off);
    hit_idx = '0;
    for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit_idx = ROW_LOG'(i);
      end
    end
    hit_label = {cur_row, hit_idx};
    next_row  = {1'b0, cur_row} + (ADDR_BITS + 1)'(1);
  end

  // Cursor: 1 on a clear, else one after the label found or the next row start.
  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.clr_start) begin
      cursor_nxt = (LABEL_BITS + 1)'(1);
    end else if (cmd.scan_chk) begin
      if (|masked) begin
        cursor_nxt = {1'b0, hit_label} + (LABEL_BITS + 1)'(1);
      end else begin
        cursor_nxt = {next_row, {ROW_LOG{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= (LABEL_BITS + 1)'(1);
      clr_cnt_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_BITS'(1);
      end
    end
  end

  // Pending result of a fetch.
  assign lab_ext = {{FIELD_BITS{1'b0}}, hit_label};

  always_ff @(posedge clk) begin
    if (cmd.res_hit) begin
      res_label_r <= lab_ext[FIELD_BITS-1:0];
      res_found_r <= 1'b1;
    end else if (cmd.res_none) begin
      res_label_r <= '0;
      res_found_r <= 1'b0;
    end
  end

  // Output register, so a waiting result does not hold up new requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.changed_label <= res_label_r;
      out_data_r.label_found   <= res_found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.clr_last    = (clr_cnt_r == {ADDR_BITS{1'b1}});
  assign status.labels_diff = (old_r != new_r);
  assign status.cursor_done = cursor_r[LABEL_BITS];
  assign status.row_hit     = |masked;
  assign status.out_free    = !out_valid_r || !out_stall;

endmodule : cls_dp

`default_nettype wire

### hdl/cls_ctrl.sv
// Controller of the changed label set tracker: sequences clearing sweeps,
// mark writes and row scans. Depends on cls_pkg.
`default_nettype none

module cls_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire cls_pkg::req_t    req_type,
  input  wire cls_pkg::status_t status,
  output logic                  in_stall,
  output cls_pkg::cmd_t         cmd
);

  import cls_pkg::*;

  state_t state_r, state_nxt;

  // State register; reset starts with a clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          unique case (req_type)
            REQ_PAIR:  state_nxt = ST_MARK_A;
            REQ_FETCH: state_nxt = ST_SCAN_RD;
            REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MARK_A: begin
        if (status.labels_diff) begin
          cmd.mark_a = 1'b1;
          state_nxt  = ST_MARK_B;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MARK_B: begin
        cmd.mark_b = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (status.cursor_done) begin
          cmd.res_none = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (status.row_hit) begin
          cmd.res_hit = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule : cls_ctrl

`default_nettype wire

### hdl/changed_label_set_tracker.sv
// Top level of the changed label set tracker: controller plus datapath.
// Depends on cls_pkg, cls_ctrl and cls_dp.
//
// Voxel label pairs mark both labels in a one-bit-per-label map whenever
// they differ; a fetch returns the next marked nonzero label at or above the
// scan cursor in ascending order, or label_found 0 once the scan is exhausted,
// and a clear empties the map and returns the cursor to label 1. The map is
// a memory of 2**(LABEL_BITS-3) rows of eight marks with one write and one
// read port. After reset and after each clear request the block sweeps the
// map one row a cycle and holds in_stall high meanwhile. A pair writes its
// two marks one after the other when its labels differ, because the two
// marks share the one write port, and writes none when they are equal. A
// fetch reads and then checks each eight-label row passed by the scan, and
// waits in ST_DONE until the output register is free. Results go out
// through a register, so new requests are taken while a result waits on
// out_stall.
`default_nettype none

module changed_label_set_tracker #(
  parameter int LABEL_BITS = cls_pkg::LABEL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cls_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cls_pkg::out_item_t      out_data
);

  import cls_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing of sweeps, marks and scans.
  cls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Map memory, cursor and output register.
  cls_dp #(
    .LABEL_BITS (LABEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule : changed_label_set_tracker

`default_nettype wire
